// ----- hdl/sat_pkg.sv -----
package sat_pkg;

    localparam int MAX_SECTIONS = 16;
    localparam int IDX_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CNT_W        = $clog2(MAX_SECTIONS + 1);
    localparam int CFG_W        = 5;
    localparam int CMP_W        = (CFG_W > CNT_W) ? CFG_W : CNT_W;

    localparam int ADDR_W       = 32;
    localparam int ENTRY_IDX_W  = 4;
    localparam int S_TDATA_W    = 168;
    localparam int M_TDATA_W    = 32;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_V2R   = 2'd1,
        OP_R2V   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NOMATCH = 2'd1,
        STAT_BEYOND  = 2'd2,
        STAT_WRITTEN = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] rlen;
        logic [ADDR_W-1:0] rbase;
        logic [ADDR_W-1:0] vlen;
        logic [ADDR_W-1:0] vbase;
    } entry_t;

    typedef struct packed {
        logic              hit;
        status_t           status;
        logic [ADDR_W-1:0] addr;
    } match_t;

endpackage

// ----- hdl/sat_table.sv -----
module sat_table (
    input  logic                        aclk,
    input  logic                        we,
    input  logic [sat_pkg::IDX_W-1:0]   waddr,
    input  sat_pkg::entry_t             wdata,
    input  logic                        re,
    input  logic [sat_pkg::IDX_W-1:0]   raddr,
    output sat_pkg::entry_t             rdata
);

    sat_pkg::entry_t mem [sat_pkg::MAX_SECTIONS];
    sat_pkg::entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, enabled by re; rdata holds its last entry otherwise
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/sat_match.sv -----
module sat_match (
    input  sat_pkg::entry_t                 entry,
    input  sat_pkg::op_t                    op,
    input  logic [sat_pkg::ADDR_W-1:0]      query,
    output sat_pkg::match_t                 match
);

    logic [sat_pkg::ADDR_W:0]   vend;
    logic [sat_pkg::ADDR_W:0]   rend;
    logic [sat_pkg::ADDR_W-1:0] fwd_off;
    logic [sat_pkg::ADDR_W-1:0] rev_addr;
    logic                       in_virt;
    logic                       in_raw;
    logic                       beyond;

    always_comb begin
        vend     = {1'b0, entry.vbase} + {1'b0, entry.vlen};
        rend     = {1'b0, entry.rbase} + {1'b0, entry.rlen};
        in_virt  = (query >= entry.vbase) && ({1'b0, query} < vend);
        // zero raw size leaves an empty raw window
        in_raw   = (query >= entry.rbase) && ({1'b0, query} < rend);
        fwd_off  = (query - entry.vbase) + entry.rbase;
        rev_addr = entry.vbase + (query - entry.rbase);
        beyond   = (entry.rlen != '0) && ({1'b0, fwd_off} >= rend);

        match.hit    = 1'b0;
        match.status = sat_pkg::STAT_NOMATCH;
        match.addr   = '0;
        case (op)
            sat_pkg::OP_V2R: begin
                if (in_virt) begin
                    match.hit    = 1'b1;
                    match.status = beyond ? sat_pkg::STAT_BEYOND : sat_pkg::STAT_OK;
                    match.addr   = beyond ? '0 : fwd_off;
                end
            end
            sat_pkg::OP_R2V: begin
                if (in_raw) begin
                    match.hit    = 1'b1;
                    match.status = sat_pkg::STAT_OK;
                    match.addr   = rev_addr;
                end
            end
            default: begin
                match.hit = 1'b0;
            end
        endcase
    end

endmodule

// ----- hdl/section_address_translator_top.sv -----
// a write, an unused op or n = 0 goes from idle straight to the response state
// a query reads entries 0 to n - 1 in order and ends at the first hit or after the last entry,
// n = min(window_count, MAX_SECTIONS) sets the scan length, one table read per cycle
// throughput: one item at a time; a new input beat is taken only in idle,
// the cycle after the result is handed to the output register
// reset: aresetn sync active low clears control and window_count; table undefined until written
module section_address_translator_top (
    input  logic                            aclk,
    input  logic                            aresetn,

    // configuration: window_count
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sat_pkg::CFG_W-1:0]       cfg_data,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    // entry_index[3:0], virt_base[35:4], virt_length[67:36], raw_base[99:68],
    // raw_length[131:100], query_addr[163:132], zero pad[167:164]
    input  logic [sat_pkg::S_TDATA_W-1:0]   s_tdata,
    // operation[1:0]
    input  logic [1:0]                      s_tuser,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // result_addr[31:0]
    output logic [sat_pkg::M_TDATA_W-1:0]   m_tdata,
    // status[1:0]
    output logic [1:0]                      m_tuser
);

    // input beat unpacking
    logic [sat_pkg::ENTRY_IDX_W-1:0] in_idx;
    sat_pkg::entry_t                 in_entry;
    logic [sat_pkg::ADDR_W-1:0]      in_query;
    sat_pkg::op_t                    in_op;
    logic                            s_accept;

    assign in_idx         = s_tdata[3:0];
    assign in_entry.vbase = s_tdata[35:4];
    assign in_entry.vlen  = s_tdata[67:36];
    assign in_entry.rbase = s_tdata[99:68];
    assign in_entry.rlen  = s_tdata[131:100];
    assign in_query       = s_tdata[163:132];
    assign in_op          = sat_pkg::op_t'(s_tuser);

    // registers
    sat_pkg::state_t                 state_reg, state_next;
    logic [sat_pkg::CFG_W-1:0]       count_reg;
    sat_pkg::op_t                    op_reg, op_next;
    logic [sat_pkg::ADDR_W-1:0]      query_reg, query_next;
    logic [sat_pkg::CNT_W-1:0]       n_reg, n_next;
    logic [sat_pkg::CNT_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic                            dv_reg, dv_next;
    logic                            last_reg, last_next;
    sat_pkg::status_t                res_status_reg, res_status_next;
    logic [sat_pkg::ADDR_W-1:0]      res_addr_reg, res_addr_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    sat_pkg::status_t                m_status_reg, m_status_next;
    logic [sat_pkg::ADDR_W-1:0]      m_addr_reg, m_addr_next;

    // active entry count, clamped to the table depth
    logic [sat_pkg::CMP_W-1:0]       count_ext;
    logic [sat_pkg::CMP_W-1:0]       count_clamp;
    logic [sat_pkg::CNT_W-1:0]       active_n;

    assign count_ext   = sat_pkg::CMP_W'(count_reg);
    assign count_clamp = (count_ext > sat_pkg::CMP_W'(sat_pkg::MAX_SECTIONS)) ?
                         sat_pkg::CMP_W'(sat_pkg::MAX_SECTIONS) : count_ext;
    assign active_n    = count_clamp[sat_pkg::CNT_W-1:0];

    // table ports
    logic                            tbl_we;
    logic [sat_pkg::IDX_W-1:0]       tbl_waddr;
    logic                            tbl_re;
    logic [sat_pkg::IDX_W-1:0]       tbl_raddr;
    sat_pkg::entry_t                 tbl_rdata;
    sat_pkg::match_t                 match;
    logic                            out_load;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == sat_pkg::S_IDLE);
    assign s_accept  = s_tvalid && s_tready;

    // writes land in the table on the accepting edge; an index past the depth is dropped
    assign tbl_we    = s_accept && (in_op == sat_pkg::OP_WRITE) &&
                       (32'(in_idx) < 32'(sat_pkg::MAX_SECTIONS));
    assign tbl_waddr = sat_pkg::IDX_W'(in_idx);

    // scan issues one read per cycle until the count is reached or a window hits
    assign tbl_re    = (state_reg == sat_pkg::S_SCAN) && (rd_ptr_reg < n_reg) &&
                       !(dv_reg && match.hit);
    assign tbl_raddr = rd_ptr_reg[sat_pkg::IDX_W-1:0];

    assign out_load  = (state_reg == sat_pkg::S_RESP) && (!m_tvalid_reg || m_tready);

    sat_table u_table (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (in_entry),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    sat_match u_match (
        .entry (tbl_rdata),
        .op    (op_reg),
        .query (query_reg),
        .match (match)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sat_pkg::S_IDLE: begin
                if (s_accept) begin
                    if (((in_op == sat_pkg::OP_V2R) || (in_op == sat_pkg::OP_R2V)) &&
                        (active_n != '0)) begin
                        state_next = sat_pkg::S_SCAN;
                    end else begin
                        state_next = sat_pkg::S_RESP;
                    end
                end
            end
            sat_pkg::S_SCAN: begin
                if (dv_reg && (match.hit || last_reg)) begin
                    state_next = sat_pkg::S_RESP;
                end
            end
            sat_pkg::S_RESP: begin
                if (out_load) begin
                    state_next = sat_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = sat_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and output register
    always_comb begin
        op_next         = op_reg;
        query_next      = query_reg;
        n_next          = n_reg;
        rd_ptr_next     = rd_ptr_reg;
        dv_next         = 1'b0;
        last_next       = 1'b0;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_addr_next     = m_addr_reg;

        case (state_reg)
            sat_pkg::S_IDLE: begin
                if (s_accept) begin
                    op_next         = in_op;
                    query_next      = in_query;
                    n_next          = active_n;
                    rd_ptr_next     = '0;
                    res_addr_next   = '0;
                    // writes answer at once; unused op and empty table miss
                    res_status_next = (in_op == sat_pkg::OP_WRITE) ?
                                      sat_pkg::STAT_WRITTEN : sat_pkg::STAT_NOMATCH;
                end
            end
            sat_pkg::S_SCAN: begin
                if (tbl_re) begin
                    rd_ptr_next = rd_ptr_reg + sat_pkg::CNT_W'(1);
                    dv_next     = 1'b1;
                    last_next   = (rd_ptr_reg == (n_reg - sat_pkg::CNT_W'(1)));
                end
                if (dv_reg) begin
                    if (match.hit) begin
                        res_status_next = match.status;
                        res_addr_next   = match.addr;
                    end else if (last_reg) begin
                        res_status_next = sat_pkg::STAT_NOMATCH;
                        res_addr_next   = '0;
                    end
                end
            end
            sat_pkg::S_RESP: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_addr_next   = res_addr_reg;
                end
            end
            default: begin
                dv_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sat_pkg::S_IDLE;
            count_reg    <= '0;
            dv_reg       <= 1'b0;
            last_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            dv_reg       <= dv_next;
            last_reg     <= last_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                count_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        query_reg      <= query_next;
        n_reg          <= n_next;
        rd_ptr_reg     <= rd_ptr_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        m_status_reg   <= m_status_next;
        m_addr_reg     <= m_addr_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = m_addr_reg;

    // a table write never overlaps a scan read
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(tbl_we && tbl_re))
        else $error("table write and read in the same cycle");

    // every accepted beat leaves idle, so no second beat slips in
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg != sat_pkg::S_IDLE))
        else $error("accepted beat did not start work");

    // the read pointer never runs past the active count
    a_ptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sat_pkg::S_SCAN) |-> (rd_ptr_reg <= n_reg))
        else $error("scan read pointer past active count");

    // a new output beat only comes from the response state
    a_out_from_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !$past(m_tvalid_reg && !m_tready)) |->
        $past(state_reg == sat_pkg::S_RESP))
        else $error("output beat raised outside response state");

endmodule
